// ===== hw/rtl/irbad_pkg.sv =====
package irbad_pkg;

	// field widths of the transaction payloads
	localparam int unsigned SAMPLE_BITS = 10;
	localparam int unsigned STAMP_BITS  = 32;
	localparam int unsigned DIST_BITS   = 16;

	// configuration register widths
	localparam int unsigned SLOPE_W     = 16;
	localparam int unsigned OFFSET_W    = 22;
	localparam int unsigned BIAS_W      = 18;
	localparam int unsigned CFG_DATA_W  = 22;
	localparam int unsigned CFG_INDEX_W = 3;

	// default block length
	localparam int unsigned AVERAGE_LENGTH_DEF = 16;

	// datapath widths
	localparam int unsigned MA_W      = SLOPE_W + SAMPLE_BITS;
	localparam int unsigned DEN_W     = MA_W + 2;
	localparam int unsigned DABS_W    = DEN_W - 1;
	localparam int unsigned KD_W      = BIAS_W + DEN_W;
	localparam int unsigned MAG_W     = KD_W - 1;
	localparam int unsigned SCALE_W   = 10;
	localparam int unsigned X_W       = MAG_W + SCALE_W;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned QUO_BITS  = 20;
	localparam int unsigned REM_W     = DABS_W + FRAC_BITS + QUO_BITS;
	localparam int unsigned DSH_W     = REM_W - 1;
	localparam int unsigned Q10_W     = 17;
	localparam int unsigned H_W       = Q10_W + 1;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned TEN_SH    = 23;

	// arithmetic constants
	localparam logic signed [KD_W-1:0] ONE_Q32     = KD_W'(64'd4294967296);
	localparam logic [SCALE_W-1:0]     SCALE_K     = 10'd1000;
	localparam logic [QUO_BITS-1:0]    TEN_RECIP   = 20'd838861;
	localparam logic [QUO_BITS-1:0]    DIGIT_BASE  = 20'd10;
	localparam logic [DIGIT_W-1:0]     ROUND_DIGIT = 4'd4;
	localparam logic signed [DIST_BITS-1:0] DIST_MAX = 16'sh7fff;
	localparam logic signed [DIST_BITS-1:0] DIST_MIN = 16'sh8000;

	// register reset values
	localparam logic [SLOPE_W-1:0]         FRONT_SLOPE_RST  = 16'd2215;
	localparam logic signed [OFFSET_W-1:0] FRONT_OFFSET_RST = 22'sd11915;
	localparam logic signed [BIAS_W-1:0]   FRONT_BIAS_RST   = 18'sd3749;
	localparam logic [SLOPE_W-1:0]         BACK_SLOPE_RST   = 16'd2733;
	localparam logic signed [OFFSET_W-1:0] BACK_OFFSET_RST  = -22'sd70071;
	localparam logic signed [BIAS_W-1:0]   BACK_BIAS_RST    = 18'sd3211;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRONT_SLOPE,
		REG_FRONT_OFFSET,
		REG_FRONT_BIAS,
		REG_BACK_SLOPE,
		REG_BACK_OFFSET,
		REG_BACK_BIAS
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] front_sample;
		logic [SAMPLE_BITS-1:0] back_sample;
		logic [STAMP_BITS-1:0]  sample_time;
	} in_item_t;

	typedef struct packed {
		logic [STAMP_BITS-1:0]        stamp_out;
		logic signed [DIST_BITS-1:0] front_distance;
		logic signed [DIST_BITS-1:0] back_distance;
		logic                         front_div_zero;
		logic                         back_div_zero;
	} out_item_t;

	// datapath step selected by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_DEN,
		OP_KD,
		OP_NUM,
		OP_ABS,
		OP_SCALE,
		OP_CHECK,
		OP_DIV,
		OP_TEN,
		OP_ROUND
	} op_t;

	typedef struct packed {
		logic accumulate;
		logic start;
		op_t  op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
	} status_t;

endpackage

// ===== hw/rtl/irbad_chan.sv =====
module irbad_chan #(
	parameter int unsigned AVERAGE_LENGTH = irbad_pkg::AVERAGE_LENGTH_DEF
) (
	input  logic                                                clk,
	input  irbad_pkg::cmd_t                                     cmd,
	input  logic [irbad_pkg::SAMPLE_BITS+$clog2(AVERAGE_LENGTH)-1:0] sum,
	input  logic [irbad_pkg::SLOPE_W-1:0]                       slope,
	input  logic signed [irbad_pkg::OFFSET_W-1:0]               offset,
	input  logic signed [irbad_pkg::BIAS_W-1:0]                 bias,
	output logic signed [irbad_pkg::DIST_BITS-1:0]              distance,
	output logic                                                div_zero
);
	import irbad_pkg::*;

	// reciprocal of the block length, exact for every reachable sum
	localparam int unsigned SUM_W   = SAMPLE_BITS + $clog2(AVERAGE_LENGTH);
	localparam int unsigned AL_LOG  = $clog2(AVERAGE_LENGTH);
	localparam int unsigned RSH     = SUM_W + AL_LOG;
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP =
		((64'd1 << RSH) + AVERAGE_LENGTH - 1) / AVERAGE_LENGTH;

	localparam logic [H_W-1:0] POS_LIMIT = H_W'(2 ** (DIST_BITS - 1) - 1);
	localparam logic [H_W-1:0] NEG_LIMIT = H_W'(2 ** (DIST_BITS - 1));

	logic [PROD_W-1:0]       prod_q;
	logic signed [DEN_W-1:0] den_q;
	logic signed [KD_W-1:0]  kd_q;
	logic                    den_zero_q;
	logic                    den_neg_q;
	logic [DABS_W-1:0]       dabs_q;
	logic signed [KD_W-1:0]  num_q;
	logic                    neg_q;
	logic [MAG_W-1:0]        p_q;
	logic [X_W-1:0]          x_q;
	logic                    ovf_q;
	logic [REM_W-1:0]        rem_q;
	logic [DSH_W-1:0]        dsh_q;
	logic [QUO_BITS-1:0]     quo_q;
	logic [Q10_W-1:0]        q10_q;
	logic                    nz_q;
	logic signed [DIST_BITS-1:0] dist_q;
	logic                    div_zero_q;

	logic [SAMPLE_BITS-1:0]  avg;
	logic [MA_W-1:0]         ma;
	logic [REM_W-1:0]        dsh_ext;
	logic [2*QUO_BITS-1:0]   tprod;
	logic [QUO_BITS-1:0]     q10x10;
	logic [QUO_BITS-1:0]     digit_full;
	logic [DIGIT_W-1:0]      digit;
	logic [H_W-1:0]          hp;
	logic [H_W-1:0]          hm;
	logic [H_W-1:0]          hm_neg;

	// average is the scaled product shifted down
	assign avg        = prod_q[RSH +: SAMPLE_BITS];
	assign ma         = MA_W'(slope) * MA_W'(avg);
	assign dsh_ext    = {1'b0, dsh_q};
	assign tprod      = (2 * QUO_BITS)'(quo_q) * (2 * QUO_BITS)'(TEN_RECIP);
	assign q10x10     = QUO_BITS'(q10_q) * DIGIT_BASE;
	assign digit_full = quo_q - q10x10;
	assign digit      = digit_full[DIGIT_W-1:0];

	// positive: round half up on thousandths; negative: always towards minus
	assign hp     = {1'b0, q10_q} + H_W'(digit > ROUND_DIGIT);
	assign hm     = {1'b0, q10_q} + H_W'(nz_q || (digit != '0));
	assign hm_neg = -hm;

	// block average of the sum, captured as the sums clear
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			prod_q <= PROD_W'(sum) * PROD_W'(RECIP);
		end
	end

	// one arithmetic step per command
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_DEN: begin
				den_q <= $signed({2'b00, ma}) + DEN_W'(offset);
			end
			OP_KD: begin
				kd_q       <= KD_W'(bias) * KD_W'(den_q);
				den_zero_q <= (den_q == '0);
				den_neg_q  <= den_q[DEN_W-1];
				dabs_q     <= den_q[DEN_W-1] ? DABS_W'(-den_q) : DABS_W'(den_q);
			end
			OP_NUM: begin
				if (den_neg_q) begin
					num_q <= kd_q - ONE_Q32;
				end else begin
					num_q <= ONE_Q32 - kd_q;
				end
			end
			OP_ABS: begin
				neg_q <= num_q[KD_W-1];
				p_q   <= num_q[KD_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
			end
			OP_SCALE: begin
				x_q <= X_W'(p_q) * X_W'(SCALE_K);
			end
			OP_CHECK: begin
				// quotient too large for the divider saturates anyway
				ovf_q <= {{(REM_W-X_W){1'b0}}, x_q} >=
					{dabs_q, {(FRAC_BITS+QUO_BITS){1'b0}}};
				rem_q <= {{(REM_W-X_W){1'b0}}, x_q};
				dsh_q <= {dabs_q, {(FRAC_BITS+QUO_BITS-1){1'b0}}};
				quo_q <= '0;
			end
			OP_DIV: begin
				// restoring division, one quotient bit
				if (rem_q >= dsh_ext) begin
					rem_q <= rem_q - dsh_ext;
					quo_q <= {quo_q[QUO_BITS-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_BITS-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			OP_TEN: begin
				q10_q <= tprod[TEN_SH +: Q10_W];
				nz_q  <= |rem_q;
			end
			OP_ROUND: begin
				div_zero_q <= den_zero_q;
				if (den_zero_q) begin
					dist_q <= DIST_MAX;
				end else if (ovf_q) begin
					dist_q <= neg_q ? DIST_MIN : DIST_MAX;
				end else if (neg_q) begin
					dist_q <= (hm > NEG_LIMIT) ? DIST_MIN : $signed(hm_neg[DIST_BITS-1:0]);
				end else begin
					dist_q <= (hp > POS_LIMIT) ? DIST_MAX : $signed(hp[DIST_BITS-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	assign distance = dist_q;
	assign div_zero = div_zero_q;

endmodule

// ===== hw/rtl/irbad_dp.sv =====
module irbad_dp #(
	parameter int unsigned AVERAGE_LENGTH = irbad_pkg::AVERAGE_LENGTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  irbad_pkg::cmd_t                  cmd,
	output irbad_pkg::status_t               status,
	input  logic                             cfg_we,
	input  logic [irbad_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [irbad_pkg::CFG_DATA_W-1:0] cfg_data,
	input  irbad_pkg::in_item_t              in_data,
	output irbad_pkg::out_item_t             out_data
);
	import irbad_pkg::*;

	localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(AVERAGE_LENGTH);
	localparam int unsigned CNT_W = $clog2(AVERAGE_LENGTH + 1);

	logic [SLOPE_W-1:0]         front_slope_q;
	logic signed [OFFSET_W-1:0] front_offset_q;
	logic signed [BIAS_W-1:0]   front_bias_q;
	logic [SLOPE_W-1:0]         back_slope_q;
	logic signed [OFFSET_W-1:0] back_offset_q;
	logic signed [BIAS_W-1:0]   back_bias_q;

	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      front_sum_q;
	logic [SUM_W-1:0]      back_sum_q;
	logic [STAMP_BITS-1:0] stamp_q;
	out_item_t             out_q;

	logic signed [DIST_BITS-1:0] front_dist;
	logic signed [DIST_BITS-1:0] back_dist;
	logic                        front_dz;
	logic                        back_dz;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_slope_q  <= FRONT_SLOPE_RST;
			front_offset_q <= FRONT_OFFSET_RST;
			front_bias_q   <= FRONT_BIAS_RST;
			back_slope_q   <= BACK_SLOPE_RST;
			back_offset_q  <= BACK_OFFSET_RST;
			back_bias_q    <= BACK_BIAS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRONT_SLOPE:  front_slope_q  <= cfg_data[SLOPE_W-1:0];
				REG_FRONT_OFFSET: front_offset_q <= $signed(cfg_data[OFFSET_W-1:0]);
				REG_FRONT_BIAS:   front_bias_q   <= $signed(cfg_data[BIAS_W-1:0]);
				REG_BACK_SLOPE:   back_slope_q   <= cfg_data[SLOPE_W-1:0];
				REG_BACK_OFFSET:  back_offset_q  <= $signed(cfg_data[OFFSET_W-1:0]);
				REG_BACK_BIAS:    back_bias_q    <= $signed(cfg_data[BIAS_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// block sums and sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			front_sum_q <= '0;
			back_sum_q  <= '0;
		end else if (cmd.start) begin
			count_q     <= '0;
			front_sum_q <= '0;
			back_sum_q  <= '0;
		end else if (cmd.accumulate) begin
			count_q     <= count_q + CNT_W'(1);
			front_sum_q <= front_sum_q + SUM_W'(in_data.front_sample);
			back_sum_q  <= back_sum_q + SUM_W'(in_data.back_sample);
		end
	end

	assign status.full = (count_q >= CNT_W'(AVERAGE_LENGTH));

	// timestamp of the emitting transaction
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			stamp_q <= in_data.sample_time;
		end
	end

	irbad_chan #(
		.AVERAGE_LENGTH(AVERAGE_LENGTH)
	) u_front (
		.clk     (clk),
		.cmd     (cmd),
		.sum     (front_sum_q),
		.slope   (front_slope_q),
		.offset  (front_offset_q),
		.bias    (front_bias_q),
		.distance(front_dist),
		.div_zero(front_dz)
	);

	irbad_chan #(
		.AVERAGE_LENGTH(AVERAGE_LENGTH)
	) u_back (
		.clk     (clk),
		.cmd     (cmd),
		.sum     (back_sum_q),
		.slope   (back_slope_q),
		.offset  (back_offset_q),
		.bias    (back_bias_q),
		.distance(back_dist),
		.div_zero(back_dz)
	);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.stamp_out      <= stamp_q;
			out_q.front_distance <= front_dist;
			out_q.back_distance  <= back_dist;
			out_q.front_div_zero <= front_dz;
			out_q.back_div_zero  <= back_dz;
		end
	end

	assign out_data = out_q;

endmodule

// ===== hw/rtl/irbad_ctrl.sv =====
module irbad_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  irbad_pkg::status_t status,
	output irbad_pkg::cmd_t    cmd
);
	import irbad_pkg::*;

	localparam int unsigned DCNT_W = $clog2(QUO_BITS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEN,
		ST_KD,
		ST_NUM,
		ST_ABS,
		ST_SCALE,
		ST_CHECK,
		ST_DIV,
		ST_TEN,
		ST_ROUND,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic              out_valid_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// command decode
	always_comb begin
		cmd.accumulate = in_fire && !status.full;
		cmd.start      = in_fire && status.full;
		cmd.out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
		unique case (state_q)
			ST_DEN:   cmd.op = OP_DEN;
			ST_KD:    cmd.op = OP_KD;
			ST_NUM:   cmd.op = OP_NUM;
			ST_ABS:   cmd.op = OP_ABS;
			ST_SCALE: cmd.op = OP_SCALE;
			ST_CHECK: cmd.op = OP_CHECK;
			ST_DIV:   cmd.op = OP_DIV;
			ST_TEN:   cmd.op = OP_TEN;
			ST_ROUND: cmd.op = OP_ROUND;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_DEN;
					end
				end
				ST_DEN:   state_q <= ST_KD;
				ST_KD:    state_q <= ST_NUM;
				ST_NUM:   state_q <= ST_ABS;
				ST_ABS:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_CHECK;
				ST_CHECK: begin
					div_cnt_q <= DCNT_W'(QUO_BITS - 1);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_TEN;
					end else begin
						div_cnt_q <= div_cnt_q - DCNT_W'(1);
					end
				end
				ST_TEN:   state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/ir_block_average_distance_unit.sv =====
// infrared range converter, front and back channels, block averaged
// input channel in_valid/in_ready carries in_data: both adc samples and a
// timestamp. AVERAGE_LENGTH transactions are summed, one per cycle while
// in_ready is high, with no result. the next transaction is not summed: it
// triggers one result on the out_valid/out_ready channel carrying its
// timestamp, both distances in signed hundredths and the zero denominator
// flags, and clears the sums. an accumulating transaction leaves the input
// open; after an emitting transaction in_ready stays low until its result
// is loaded into the output register. the result is computed by a 20-step
// restoring divider that forms the quotient, one quotient bit a cycle,
// plus single steps for average, denominator, numerator and rounding.
// a finished result sits in the output register; while it waits, further
// transactions are still summed, and the next emitting one is computed and
// then held until the output register is free.
// reset clears the sums and count, loads the calibration defaults and drops
// any pending result. configuration writes through cfg_we/cfg_index/cfg_data
// take effect at once and are meant for idle periods only.
module ir_block_average_distance_unit #(
	parameter int unsigned AVERAGE_LENGTH = irbad_pkg::AVERAGE_LENGTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  irbad_pkg::in_item_t               in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output irbad_pkg::out_item_t              out_data,
	input  logic                              cfg_we,
	input  logic [irbad_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [irbad_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import irbad_pkg::*;

	cmd_t    cmd;
	status_t status;

	irbad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	irbad_dp #(
		.AVERAGE_LENGTH(AVERAGE_LENGTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// ===== hw/rtl/irbad_checker.sv =====
module irbad_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input irbad_pkg::out_item_t              out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// a result appears only at the end of a computation
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while input side was open");

	// input closes only after a transaction was accepted
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("input closed without an accepted transaction");

	// input reopens only with a result in the output register
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("input reopened without a result");

endmodule

bind ir_block_average_distance_unit irbad_checker u_checker (.*);
